FILE: hw/rtl/priority_bitmap_run_queue_unit_defines.svh
// assertion macros for the run queue unit
// no dependencies; included by files that carry concurrent checks
`ifndef PRIORITY_BITMAP_RUN_QUEUE_UNIT_DEFINES_SVH
`define PRIORITY_BITMAP_RUN_QUEUE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PBRQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PBRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBRQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PBRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/pbrq_pkg.sv
// shared types, constants and helpers for the run queue unit
// no dependencies
`timescale 1ns / 1ps
package pbrq_pkg;
  localparam int NumEntities = 64;
  localparam int NumLevels   = 32;
  localparam int EntW  = $clog2(NumEntities);
  localparam int LvlW  = $clog2(NumLevels);
  localparam int PrioW = 8;
  localparam int StepW = 16;
  localparam int KcntW = 10;
  localparam int CntW  = $clog2(NumEntities + 1);

  typedef enum logic [1:0] {
    OP_WAKE   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SCHED  = 2'd2,
    OP_REPORT = 2'd3
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd_ent;
    logic rd_list;
    logic exec;
  } pbrq_cmd_t;

  typedef struct packed {
    logic [LvlW-1:0]  level;
    logic [PrioW-1:0] prio;
    logic [StepW-1:0] step;
  } ent_rec_t;

  // lowest set bit of the level bitmap
  function automatic logic [LvlW-1:0] lowest_level(input logic [NumLevels-1:0] bm);
    logic [LvlW-1:0] res;
    res = LvlW'(NumLevels - 1);
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (bm[i]) begin
        res = LvlW'(i);
      end
    end
    return res;
  endfunction
endpackage

FILE: hw/rtl/pbrq_ctrl.sv
// sequencing state machine of the run queue unit
// depends on pbrq_pkg
`timescale 1ns / 1ps
module pbrq_ctrl import pbrq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output pbrq_cmd_t cmd_o
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD1  = 4'b0010,
    ST_RD2  = 4'b0100,
    ST_EXE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd_o.rd_ent = 1'b1;
        state_d      = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd_list = 1'b1;
        state_d       = ST_EXE;
      end
      ST_EXE: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

FILE: hw/rtl/pbrq_datapath.sv
// list tables, bitmap, current entity state and result registers
// depends on pbrq_pkg
`timescale 1ns / 1ps
module pbrq_datapath import pbrq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pbrq_cmd_t        cmd_i,
  input  logic [1:0]       operation_i,
  input  logic [EntW-1:0]  entity_id_i,
  input  logic [LvlW-1:0]  queue_level_i,
  input  logic [PrioW-1:0] task_priority_i,
  input  logic [StepW-1:0] step_budget_i,
  input  logic [KcntW-1:0] kernel_count_i,
  input  logic             has_more_work_i,
  output logic             result_valid_o,
  output logic             wake_worker_o,
  output logic             performed_o,
  output logic             selected_valid_o,
  output logic [EntW-1:0]  selected_entity_o,
  output logic             switched_o,
  output logic             preempted_switch_o,
  output logic             went_idle_o,
  output logic [CntW-1:0]  queued_count_o
);
  // latched item
  op_e              op_q;
  logic [EntW-1:0]  id_q;
  logic [LvlW-1:0]  lvl_q;
  logic [PrioW-1:0] tprio_q;
  logic [StepW-1:0] budget_q;
  logic [KcntW-1:0] kcount_q;
  logic             more_q;

  // memories
  ent_rec_t        ent_mem  [NumEntities];
  logic [EntW-1:0] next_mem [NumEntities];
  logic [EntW-1:0] prev_mem [NumEntities];
  logic [EntW-1:0] head_mem [NumLevels];
  logic [EntW-1:0] tail_mem [NumLevels];
  ent_rec_t        ent_rd_q;
  logic [EntW-1:0] next_rd_q, prev_rd_q, head_rd_q, tail_rd_q;

  // control state
  logic [NumEntities-1:0] queued_q, queued_d;
  logic [NumLevels-1:0]   bitmap_q, bitmap_d;
  logic [CntW-1:0]        total_q, total_d;
  logic                   cur_valid_q, cur_valid_d;
  logic [EntW-1:0]        cur_id_q, cur_id_d;
  logic                   pend_q, pend_d;
  logic [StepW-1:0]       sent_q, sent_d;
  logic                   res_valid_q;

  // result payload
  logic wake_q, wake_d, perf_q, perf_d, sw_q, sw_d, psw_q, psw_d, idle_q, idle_d;

  logic [EntW-1:0] tgt;
  logic [LvlW-1:0] list_addr;
  logic [LvlW-1:0] ul_lvl;
  logic            unlink;
  logic            blocked;
  logic            keep;
  logic [StepW:0]  sent_sum;

  logic            ent_we;
  logic            next_we, prev_we, head_we, tail_we;
  logic [EntW-1:0] next_wa, next_wd, prev_wa, prev_wd, head_wd, tail_wd;
  logic [LvlW-1:0] head_wa, tail_wa;

  assign tgt       = (op_q == OP_REMOVE) ? id_q : cur_id_q;
  assign list_addr = (op_q == OP_REMOVE || op_q == OP_REPORT) ? ent_rd_q.level :
                     (op_q == OP_SCHED) ? lowest_level(bitmap_q) : lvl_q;
  assign ul_lvl    = ent_rd_q.level;
  assign blocked   = cur_valid_q && (kcount_q == '0) && !more_q;
  assign unlink    = ((op_q == OP_REMOVE) && queued_q[id_q]) ||
                     ((op_q == OP_REPORT) && blocked && queued_q[cur_id_q]);
  assign keep      = cur_valid_q && (!pend_q || (sent_q < ent_rd_q.step));
  assign sent_sum  = {1'b0, sent_q} + (StepW + 1)'(kcount_q);

  always_comb begin
    queued_d    = queued_q;
    bitmap_d    = bitmap_q;
    total_d     = total_q;
    cur_valid_d = cur_valid_q;
    cur_id_d    = cur_id_q;
    pend_d      = pend_q;
    sent_d      = sent_q;
    wake_d = 1'b0; perf_d = 1'b0; sw_d = 1'b0; psw_d = 1'b0; idle_d = 1'b0;
    ent_we  = 1'b0;
    next_we = 1'b0; next_wa = id_q; next_wd = id_q;
    prev_we = 1'b0; prev_wa = id_q; prev_wd = id_q;
    head_we = 1'b0; head_wa = lvl_q; head_wd = id_q;
    tail_we = 1'b0; tail_wa = lvl_q; tail_wd = id_q;

    // self link of a freshly woken entity, before the list update
    if (cmd_i.rd_list && op_q == OP_WAKE && !queued_q[id_q]) begin
      next_we = 1'b1;
    end

    if (cmd_i.exec) begin
      case (op_q)
        OP_WAKE: begin
          if (!queued_q[id_q]) begin
            perf_d           = 1'b1;
            queued_d[id_q]   = 1'b1;
            ent_we           = 1'b1;
            prev_we          = 1'b1;
            if (bitmap_q[lvl_q]) begin
              next_we = 1'b1;
              next_wa = tail_rd_q;
              next_wd = id_q;
              prev_wd = tail_rd_q;
            end else begin
              head_we = 1'b1;
            end
            tail_we          = 1'b1;
            bitmap_d[lvl_q]  = 1'b1;
            total_d          = total_q + CntW'(1);
            if (!cur_valid_q) begin
              wake_d = 1'b1;
            end else if (ent_rd_q.prio > tprio_q) begin
              pend_d = 1'b1;
              wake_d = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          perf_d = queued_q[id_q];
        end
        OP_SCHED: begin
          perf_d = 1'b1;
          if (!keep) begin
            pend_d = 1'b0;
            if (bitmap_q == '0) begin
              idle_d      = 1'b1;
              cur_valid_d = 1'b0;
            end else begin
              if (!cur_valid_q || head_rd_q != cur_id_q) begin
                sw_d  = 1'b1;
                psw_d = cur_valid_q;
              end
              cur_valid_d = 1'b1;
              cur_id_d    = head_rd_q;
              sent_d      = '0;
            end
          end
        end
        OP_REPORT: begin
          if (cur_valid_q) begin
            perf_d = 1'b1;
            if (blocked) begin
              cur_valid_d = 1'b0;
              pend_d      = 1'b0;
            end else if (sent_sum[StepW]) begin
              sent_d = '1;
            end else begin
              sent_d = sent_sum[StepW-1:0];
            end
          end
        end
        default: begin
          perf_d = 1'b0;
        end
      endcase

      if (unlink) begin
        queued_d[tgt] = 1'b0;
        if (head_rd_q == tgt && tail_rd_q == tgt) begin
          bitmap_d[ul_lvl] = 1'b0;
        end else if (head_rd_q == tgt) begin
          head_we = 1'b1;
          head_wa = ul_lvl;
          head_wd = next_rd_q;
        end else if (tail_rd_q == tgt) begin
          tail_we = 1'b1;
          tail_wa = ul_lvl;
          tail_wd = prev_rd_q;
        end else begin
          next_we = 1'b1;
          next_wa = prev_rd_q;
          next_wd = next_rd_q;
          prev_we = 1'b1;
          prev_wa = next_rd_q;
          prev_wd = prev_rd_q;
        end
        if (total_q != '0) begin
          total_d = total_q - CntW'(1);
        end
        if (cur_valid_q && cur_id_q == tgt) begin
          cur_valid_d = 1'b0;
          pend_d      = 1'b0;
        end
      end
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[id_q] <= '{level: lvl_q, prio: tprio_q, step: budget_q};
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    if (cmd_i.rd_ent) begin
      ent_rd_q  <= ent_mem[tgt];
      next_rd_q <= next_mem[tgt];
      prev_rd_q <= prev_mem[tgt];
    end
    if (cmd_i.rd_list) begin
      head_rd_q <= head_mem[list_addr];
      tail_rd_q <= tail_mem[list_addr];
    end
  end

  // item capture and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(operation_i);
      id_q     <= entity_id_i;
      lvl_q    <= queue_level_i;
      tprio_q  <= task_priority_i;
      budget_q <= step_budget_i;
      kcount_q <= kernel_count_i;
      more_q   <= has_more_work_i;
    end
    if (cmd_i.exec) begin
      wake_q <= wake_d;
      perf_q <= perf_d;
      sw_q   <= sw_d;
      psw_q  <= psw_d;
      idle_q <= idle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q    <= '0;
      bitmap_q    <= '0;
      total_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_id_q    <= '0;
      pend_q      <= 1'b0;
      sent_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      queued_q    <= queued_d;
      bitmap_q    <= bitmap_d;
      total_q     <= total_d;
      cur_valid_q <= cur_valid_d;
      cur_id_q    <= cur_id_d;
      pend_q      <= pend_d;
      sent_q      <= sent_d;
      res_valid_q <= cmd_i.exec;
    end
  end

  assign result_valid_o     = res_valid_q;
  assign wake_worker_o      = wake_q;
  assign performed_o        = perf_q;
  assign switched_o         = sw_q;
  assign preempted_switch_o = psw_q;
  assign went_idle_o        = idle_q;
  assign selected_valid_o   = cur_valid_q;
  assign selected_entity_o  = cur_valid_q ? cur_id_q : '0;
  assign queued_count_o     = total_q;
endmodule

FILE: hw/rtl/priority_bitmap_run_queue_unit.sv
// top level of the bitmap priority run queue unit
// depends on pbrq_pkg, pbrq_ctrl, pbrq_datapath and the assertion macro header
//
// channel  | handshake                 | payload
// ---------+---------------------------+-------------------------------------------
// command  | start, busy               | operation_i .. has_more_work_i
// result   | result_valid_o (1 cycle)  | wake_worker_o .. queued_count_o
//
// every item goes from accept through the read states ST_RD1 and ST_RD2 of the
// entity and list tables, then the update state ST_EXE; the table read ports set this
// the result strobe shows in the cycle a new item may already be accepted
// reset clears queued flags, level bitmap, count and current entity state;
// the link and entity tables need no clearing, they are written before use
// the receiver cannot stall; busy is high while an item is being worked
`timescale 1ns / 1ps
`include "priority_bitmap_run_queue_unit_defines.svh"
module priority_bitmap_run_queue_unit import pbrq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       operation_i,
  input  logic [EntW-1:0]  entity_id_i,
  input  logic [LvlW-1:0]  queue_level_i,
  input  logic [PrioW-1:0] task_priority_i,
  input  logic [StepW-1:0] step_budget_i,
  input  logic [KcntW-1:0] kernel_count_i,
  input  logic             has_more_work_i,
  output logic             result_valid_o,
  output logic             wake_worker_o,
  output logic             performed_o,
  output logic             selected_valid_o,
  output logic [EntW-1:0]  selected_entity_o,
  output logic             switched_o,
  output logic             preempted_switch_o,
  output logic             went_idle_o,
  output logic [CntW-1:0]  queued_count_o
);
  pbrq_cmd_t cmd;

  // sequencer
  pbrq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // tables and state
  pbrq_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .operation_i        (operation_i),
    .entity_id_i        (entity_id_i),
    .queue_level_i      (queue_level_i),
    .task_priority_i    (task_priority_i),
    .step_budget_i      (step_budget_i),
    .kernel_count_i     (kernel_count_i),
    .has_more_work_i    (has_more_work_i),
    .result_valid_o     (result_valid_o),
    .wake_worker_o      (wake_worker_o),
    .performed_o        (performed_o),
    .selected_valid_o   (selected_valid_o),
    .selected_entity_o  (selected_entity_o),
    .switched_o         (switched_o),
    .preempted_switch_o (preempted_switch_o),
    .went_idle_o        (went_idle_o),
    .queued_count_o     (queued_count_o)
  );

  // accepted item keeps the unit busy
  `PBRQ_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy && !result_valid_o, "item accepted but unit not busy")
  // the result strobe follows the update cycle only
  `PBRQ_ASSERT_NEXT(a_strobe_exec, clk_i, rst_ni, cmd.exec, result_valid_o && !busy, "update cycle without result strobe")
  // no current entity reads as entity zero
  `PBRQ_ASSERT_IMPL(a_sel_zero, clk_i, rst_ni, !selected_valid_o, selected_entity_o == '0, "selected entity set without valid")
endmodule
